FILE: rtl/core/http_status_line_parser_macros.svh
// Assertion helpers for the status line parser.
// Each check samples on the rising edge of clk and is off while arst_n is low.
`ifndef HTTP_STATUS_LINE_PARSER_MACROS_SVH
`define HTTP_STATUS_LINE_PARSER_MACROS_SVH

// Same-cycle implication.
`define HSLP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HSLP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/hslp_pkg.sv
`default_nettype none
package hslp_pkg;

	typedef logic [7:0]  octet_t;
	typedef logic [15:0] status_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_REASON = 2'd1,
		EV_ACCEPT = 2'd2,
		EV_ERROR  = 2'd3
	} event_t;

	localparam octet_t CH_H     = 8'h48;
	localparam octet_t CH_T     = 8'h54;
	localparam octet_t CH_P     = 8'h50;
	localparam octet_t CH_SLASH = 8'h2F;
	localparam octet_t CH_DOT   = 8'h2E;
	localparam octet_t CH_SP    = 8'h20;
	localparam octet_t CH_CR    = 8'h0D;
	localparam octet_t CH_LF    = 8'h0A;
	localparam octet_t CH_ZERO  = 8'h30;
	localparam octet_t CH_NINE  = 8'h39;

	localparam status_t STATUS_MIN = 16'd100;

	function automatic logic is_digit(input octet_t b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// v*10 + d, saturating at 255
	function automatic octet_t acc_sat8(input octet_t v, input logic [3:0] d);
		logic [11:0] r;
		r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {8'd0, d};
		return (r > 12'd255) ? 8'hFF : r[7:0];
	endfunction

	// v*10 + d, saturating at 65535
	function automatic status_t acc_sat16(input status_t v, input logic [3:0] d);
		logic [19:0] r;
		r = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, d};
		return (r > 20'd65535) ? 16'hFFFF : r[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hslp_in_if.sv
`default_nettype none
interface hslp_in_if;
	logic              valid;
	logic              ready;
	logic              action;
	hslp_pkg::octet_t  data_byte;

	modport source (output valid, action, data_byte, input ready);
	modport sink   (input valid, action, data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hslp_out_if.sv
`default_nettype none
interface hslp_out_if;
	logic               valid;
	logic               ready;
	hslp_pkg::event_t   event_res;
	hslp_pkg::octet_t   reason_byte;
	hslp_pkg::octet_t   version_major;
	hslp_pkg::octet_t   version_minor;
	hslp_pkg::status_t  status_code;

	modport source (output valid, event_res, reason_byte, version_major, version_minor,
		status_code, input ready);
	modport sink   (input valid, event_res, reason_byte, version_major, version_minor,
		status_code, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/http_status_line_parser.sv
// Channel | Dir | Beat contents
// --------+-----+----------------------------------------------------------
// rx      | in  | action (restart), data_byte
// tx      | out | event_res, reason_byte, version_major, version_minor,
//         |     | status_code
//
// One beat in, one beat out. The path is the input register (_s1),
// then the parse step and result register. A byte can enter every cycle
// while tx does not stall. The parse step (phase decode plus one
// multiply-by-ten with saturation) sits between the input register and the result register.
// arst_n clears the phase, the accumulators and both valid flags.
// A stall on tx holds the result and the byte in _s1; rx.ready drops only
// while both are full and tx is not ready.
`default_nettype none
module http_status_line_parser (
	input  wire         clk,
	input  wire         arst_n,
	hslp_in_if.sink     rx,
	hslp_out_if.source  tx
);

	`include "http_status_line_parser_macros.svh"

	// Position in the line.
	typedef enum logic [3:0] {
		PH_H      = 4'd0,
		PH_T1     = 4'd1,
		PH_T2     = 4'd2,
		PH_P      = 4'd3,
		PH_SLASH  = 4'd4,
		PH_MAJ0   = 4'd5,
		PH_MAJ    = 4'd6,
		PH_MIN0   = 4'd7,
		PH_MIN    = 4'd8,
		PH_SP1    = 4'd9,
		PH_STAT   = 4'd10,
		PH_SP2    = 4'd11,
		PH_REASON = 4'd12,
		PH_LF     = 4'd13,
		PH_DONE   = 4'd14,
		PH_ERR    = 4'd15
	} phase_t;

	// Input register
	logic              valid_s1;
	logic              action_s1;
	hslp_pkg::octet_t  data_s1;

	// Parser state
	phase_t            phase_q;
	hslp_pkg::octet_t  major_q;
	hslp_pkg::octet_t  minor_q;
	hslp_pkg::status_t status_q;

	// Result register
	logic              out_valid_q;
	hslp_pkg::event_t  ev_q;
	hslp_pkg::octet_t  rb_q;
	hslp_pkg::octet_t  omaj_q;
	hslp_pkg::octet_t  omin_q;
	hslp_pkg::status_t ost_q;

	// Next values from the parse step
	phase_t            phase_nx;
	hslp_pkg::octet_t  major_nx;
	hslp_pkg::octet_t  minor_nx;
	hslp_pkg::status_t status_nx;
	hslp_pkg::event_t  ev_nx;
	hslp_pkg::octet_t  rb_nx;
	hslp_pkg::octet_t  omaj_nx;
	hslp_pkg::octet_t  omin_nx;
	hslp_pkg::status_t ost_nx;

	logic              digit;
	logic [3:0]        digit_val;
	logic              advance;

	// The byte in _s1 moves on when the result register is free or drains now.
	assign advance  = valid_s1 && (!out_valid_q || tx.ready);
	assign rx.ready = !valid_s1 || advance;

	assign digit     = hslp_pkg::is_digit(data_s1);
	assign digit_val = data_s1[3:0];	// '0'..'9' are 0x30..0x39

	always_comb begin
		phase_nx  = phase_q;
		major_nx  = major_q;
		minor_nx  = minor_q;
		status_nx = status_q;
		ev_nx     = hslp_pkg::EV_NONE;
		rb_nx     = '0;
		omaj_nx   = '0;
		omin_nx   = '0;
		ost_nx    = '0;
		if (action_s1) begin
			// restart: back to the first letter, accumulators cleared
			phase_nx  = PH_H;
			major_nx  = '0;
			minor_nx  = '0;
			status_nx = '0;
		end else begin
			unique case (phase_q)
				PH_H:     phase_nx = (data_s1 == hslp_pkg::CH_H) ? PH_T1 : PH_ERR;
				PH_T1:    phase_nx = (data_s1 == hslp_pkg::CH_T) ? PH_T2 : PH_ERR;
				PH_T2:    phase_nx = (data_s1 == hslp_pkg::CH_T) ? PH_P : PH_ERR;
				PH_P:     phase_nx = (data_s1 == hslp_pkg::CH_P) ? PH_SLASH : PH_ERR;
				PH_SLASH: phase_nx = (data_s1 == hslp_pkg::CH_SLASH) ? PH_MAJ0 : PH_ERR;
				PH_MAJ0, PH_MAJ: begin
					if (digit) begin
						major_nx = hslp_pkg::acc_sat8(major_q, digit_val);
						phase_nx = PH_MAJ;
					end else if (phase_q == PH_MAJ && data_s1 == hslp_pkg::CH_DOT) begin
						phase_nx = PH_MIN0;
					end else begin
						phase_nx = PH_ERR;
					end
				end
				PH_MIN0, PH_MIN: begin
					if (digit) begin
						minor_nx = hslp_pkg::acc_sat8(minor_q, digit_val);
						phase_nx = PH_MIN;
					end else if (phase_q == PH_MIN && data_s1 == hslp_pkg::CH_SP) begin
						phase_nx = PH_SP1;
					end else begin
						phase_nx = PH_ERR;
					end
				end
				PH_SP1: begin
					if (data_s1 == hslp_pkg::CH_SP) begin
						phase_nx = PH_SP1;
					end else if (digit) begin
						// first status digit starts a fresh value
						status_nx = {12'd0, digit_val};
						phase_nx  = PH_STAT;
					end else begin
						phase_nx = PH_ERR;
					end
				end
				PH_STAT: begin
					if (digit) begin
						status_nx = hslp_pkg::acc_sat16(status_q, digit_val);
						phase_nx  = PH_STAT;
					end else if (data_s1 == hslp_pkg::CH_SP &&
							status_q >= hslp_pkg::STATUS_MIN) begin
						phase_nx = PH_SP2;
					end else begin
						phase_nx = PH_ERR;
					end
				end
				PH_SP2, PH_REASON: begin
					if (data_s1 == hslp_pkg::CH_CR) begin
						phase_nx = PH_LF;
					end else if (phase_q == PH_SP2 && data_s1 == hslp_pkg::CH_SP) begin
						phase_nx = PH_SP2;
					end else begin
						// spaces count as reason bytes once the reason has begun
						ev_nx    = hslp_pkg::EV_REASON;
						rb_nx    = data_s1;
						phase_nx = PH_REASON;
					end
				end
				PH_LF: begin
					if (data_s1 == hslp_pkg::CH_LF) begin
						ev_nx    = hslp_pkg::EV_ACCEPT;
						omaj_nx  = major_q;
						omin_nx  = minor_q;
						ost_nx   = status_q;
						phase_nx = PH_DONE;
					end else begin
						phase_nx = PH_ERR;
					end
				end
				PH_DONE:  phase_nx = PH_DONE;	// trailing bytes ignored
				default:  phase_nx = PH_ERR;	// sticky error
			endcase
			if (phase_nx == PH_ERR) begin
				ev_nx = hslp_pkg::EV_ERROR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_H;
			major_q     <= '0;
			minor_q     <= '0;
			status_q    <= '0;
		end else begin
			if (rx.ready) begin
				valid_s1  <= rx.valid;
				action_s1 <= rx.action;
				data_s1   <= rx.data_byte;
			end
			if (advance) begin
				phase_q     <= phase_nx;
				major_q     <= major_nx;
				minor_q     <= minor_nx;
				status_q    <= status_nx;
				out_valid_q <= 1'b1;
				ev_q        <= ev_nx;
				rb_q        <= rb_nx;
				omaj_q      <= omaj_nx;
				omin_q      <= omin_nx;
				ost_q       <= ost_nx;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.event_res     = ev_q;
	assign tx.reason_byte   = rb_q;
	assign tx.version_major = omaj_q;
	assign tx.version_minor = omin_q;
	assign tx.status_code   = ost_q;

	`HSLP_ASSERT_NOW(a_accept_status_min,
		out_valid_q && ev_q == hslp_pkg::EV_ACCEPT, ost_q >= hslp_pkg::STATUS_MIN,
		"accepted line with status below 100")
	`HSLP_ASSERT_NOW(a_reason_zero,
		out_valid_q && ev_q != hslp_pkg::EV_REASON, rb_q == 8'd0,
		"reason byte nonzero outside a reason beat")
	`HSLP_ASSERT_NEXT(a_error_sticky,
		advance && !action_s1 && phase_q == PH_ERR,
		out_valid_q && ev_q == hslp_pkg::EV_ERROR && phase_q == PH_ERR,
		"error state left without restart")
	`HSLP_ASSERT_NEXT(a_done_holds,
		advance && !action_s1 && phase_q == PH_DONE,
		out_valid_q && ev_q == hslp_pkg::EV_NONE && phase_q == PH_DONE,
		"byte after acceptance not ignored")
	`HSLP_ASSERT_NOW(a_empty_stage_ready, !valid_s1, rx.ready,
		"input stalled with empty input register")

endmodule
`default_nettype wire

FILE: test/http_status_line_parser_tb.sv
module http_status_line_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hslp_pkg::*;

	// Run ends here no matter what. The slowest legal run is roughly
	// 2.2k beats, so this leaves plenty of margin.
	localparam int unsigned CYCLE_LIMIT = 200_000;
	localparam int RANDOM_BEATS = 1850;
	localparam int DRAIN_EVERY = 25;   // lines between full drains of the result queue
	localparam int SETTLE_CYCLES = 8;  // two-stage pipe, plus slack

	// Where the parser stands within the status line.
	typedef enum logic [3:0] {
		S_H, S_T1, S_T2, S_P, S_SLASH,
		S_MAJ_FIRST, S_MAJ, S_MIN_FIRST, S_MIN,
		S_GAP1, S_STATUS, S_GAP2, S_REASON,
		S_CR_SEEN, S_DONE, S_ERROR
	} line_phase_t;

	// One result beat, as seen on tx.
	typedef struct packed {
		event_t  ev;
		octet_t  reason;
		octet_t  major;
		octet_t  minor;
		status_t status;
	} line_result_t;

	// Tracks the parse of the byte stream and holds the results owed by the block.
	class status_line_scoreboard;
		line_result_t pending[$];
		int           fail_count;
		line_phase_t  phase;
		octet_t       major_acc;
		octet_t       minor_acc;
		status_t      status_acc;

		function new();
			fail_count = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase = S_H;
			major_acc = '0;
			minor_acc = '0;
			status_acc = '0;
		endfunction

		function bit is_numeral(octet_t b);
			return b >= CH_ZERO && b <= CH_NINE;
		endfunction

		// decimal shift-in, clamped to the field width
		function octet_t add8(octet_t v, octet_t b);
			int r;
			r = int'(v) * 10 + int'(b) - int'(CH_ZERO);
			return (r > 255) ? 8'hFF : octet_t'(r);
		endfunction

		function status_t add16(status_t v, octet_t b);
			int r;
			r = int'(v) * 10 + int'(b) - int'(CH_ZERO);
			return (r > 65535) ? 16'hFFFF : status_t'(r);
		endfunction

		// Accepted rx beat: advance the parse and queue the result it owes.
		function void note_input(logic act, octet_t b);
			line_result_t r;
			line_phase_t  nx;
			r = '0;
			nx = phase;
			if (act) begin
				clear_line();
				nx = S_H;
			end else begin
				case (phase)
					S_H:     nx = (b == CH_H) ? S_T1 : S_ERROR;
					S_T1:    nx = (b == CH_T) ? S_T2 : S_ERROR;
					S_T2:    nx = (b == CH_T) ? S_P : S_ERROR;
					S_P:     nx = (b == CH_P) ? S_SLASH : S_ERROR;
					S_SLASH: nx = (b == CH_SLASH) ? S_MAJ_FIRST : S_ERROR;
					S_MAJ_FIRST, S_MAJ: begin
						if (is_numeral(b)) begin
							major_acc = add8(major_acc, b);
							nx = S_MAJ;
						end else if (phase == S_MAJ && b == CH_DOT) begin
							nx = S_MIN_FIRST;
						end else begin
							nx = S_ERROR;
						end
					end
					S_MIN_FIRST, S_MIN: begin
						if (is_numeral(b)) begin
							minor_acc = add8(minor_acc, b);
							nx = S_MIN;
						end else if (phase == S_MIN && b == CH_SP) begin
							nx = S_GAP1;
						end else begin
							nx = S_ERROR;
						end
					end
					S_GAP1: begin
						if (b == CH_SP) begin
							nx = S_GAP1;
						end else if (is_numeral(b)) begin
							status_acc = add16('0, b);
							nx = S_STATUS;
						end else begin
							nx = S_ERROR;
						end
					end
					S_STATUS: begin
						// the at-least-100 test sees the clamped value
						if (is_numeral(b)) begin
							status_acc = add16(status_acc, b);
							nx = S_STATUS;
						end else if (b == CH_SP && status_acc >= STATUS_MIN) begin
							nx = S_GAP2;
						end else begin
							nx = S_ERROR;
						end
					end
					S_GAP2, S_REASON: begin
						// spaces are reason bytes once the reason has begun
						if (b == CH_CR) begin
							nx = S_CR_SEEN;
						end else if (phase == S_GAP2 && b == CH_SP) begin
							nx = S_GAP2;
						end else begin
							r.ev = EV_REASON;
							r.reason = b;
							nx = S_REASON;
						end
					end
					S_CR_SEEN: begin
						if (b == CH_LF) begin
							r.ev = EV_ACCEPT;
							r.major = major_acc;
							r.minor = minor_acc;
							r.status = status_acc;
							nx = S_DONE;
						end else begin
							nx = S_ERROR;
						end
					end
					S_DONE:  nx = S_DONE;
					default: nx = S_ERROR;
				endcase
				if (nx == S_ERROR)
					r.ev = EV_ERROR;
			end
			phase = nx;
			pending.push_back(r);
		endfunction

		function void compare_field(string what, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
				fail_count++;
			end
		endfunction

		// Accepted tx beat: must match the oldest owed result.
		function void check_result(line_result_t got);
			line_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: result beat with none expected, expected nothing actual event %0h",
					$time, got.ev);
				fail_count++;
				return;
			end
			want = pending.pop_front();
			compare_field("event_res", 16'(want.ev), 16'(got.ev));
			compare_field("reason_byte", 16'(want.reason), 16'(got.reason));
			compare_field("version_major", 16'(want.major), 16'(got.major));
			compare_field("version_minor", 16'(want.minor), 16'(got.minor));
			compare_field("status_code", want.status, got.status);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	hslp_in_if  rx_if();
	hslp_out_if tx_if();

	http_status_line_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	status_line_scoreboard board = new();

	octet_t      line_buf[$];     // bytes of the line about to be sent
	bit          no_idle = 1'b0;  // burst mode: neither side idles while set
	int          stall_left = 0;
	int unsigned cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Idle draw shared by both sides; burst mode forces back-to-back beats.
	function automatic int draw_idle();
		return no_idle ? 0 : $urandom_range(7, 0);
	endfunction

	// Monitor. Everything read here is the pre-edge value, since all drivers use NBAs.
	always @(posedge clk) begin
		line_result_t got;
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready)
				board.note_input(rx_if.action, rx_if.data_byte);
			if (tx_if.valid && tx_if.ready) begin
				got.ev = tx_if.event_res;
				got.reason = tx_if.reason_byte;
				got.major = tx_if.version_major;
				got.minor = tx_if.version_minor;
				got.status = tx_if.status_code;
				board.check_result(got);
			end
		end
	end

	// Result sink: after each taken beat, hold ready low for a drawn number of cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tx_if.valid && tx_if.ready) begin
				stall_left = draw_idle();
				if (stall_left != 0)
					tx_if.ready <= 1'b0;
			end else if (!tx_if.ready) begin
				stall_left--;
				if (stall_left <= 0)
					tx_if.ready <= 1'b1;
			end
		end
	end

	// One rx beat: optional gap with valid low, then hold until taken.
	// Always entered and left right after a rising edge.
	task automatic send_beat(input logic act, input octet_t b);
		int gap;
		if ($urandom_range(63, 0) == 0)
			no_idle = !no_idle;
		gap = draw_idle();
		if (gap != 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.action <= act;
		rx_if.data_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
	endtask

	task automatic send_line_buf();
		foreach (line_buf[i])
			send_beat(1'b0, line_buf[i]);
	endtask

	// Drop valid and wait out every owed result.
	task automatic drain();
		rx_if.valid <= 1'b0;
		do @(posedge clk); while (board.pending.size() != 0);
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(octet_t'(s[i]));
	endfunction

	function automatic void put_digits(int count, bit lead_nonzero);
		for (int i = 0; i < count; i++) begin
			if (i == 0 && lead_nonzero)
				line_buf.push_back(octet_t'(CH_ZERO + $urandom_range(9, 1)));
			else
				line_buf.push_back(octet_t'(CH_ZERO + $urandom_range(9, 0)));
		end
	endfunction

	// mostly short versions, now and then long enough to clamp
	function automatic int version_len();
		return ($urandom_range(7, 0) == 0) ? $urandom_range(5, 3) : $urandom_range(2, 1);
	endfunction

	// Well-formed status line with random content into line_buf.
	// low_status gives a 1-2 digit status, which the parser must reject.
	function automatic void build_line(bit low_status);
		octet_t b;
		line_buf.delete();
		put_text("HTTP/");
		put_digits(version_len(), 1'b0);
		line_buf.push_back(CH_DOT);
		put_digits(version_len(), 1'b0);
		repeat ($urandom_range(3, 1)) line_buf.push_back(CH_SP);
		if (low_status)
			put_digits($urandom_range(2, 1), 1'b0);
		else if ($urandom_range(9, 0) == 0)
			put_digits($urandom_range(6, 4), 1'b1);  // large, up to clamping
		else
			put_digits(3, 1'b1);
		repeat ($urandom_range(3, 1)) line_buf.push_back(CH_SP);
		// reason: 0 bytes means empty reason; mix of spaces, printable and raw bytes
		repeat ($urandom_range(12, 0)) begin
			case ($urandom_range(3, 0))
				0: b = CH_SP;
				1: begin
					b = octet_t'($urandom_range(255, 0));
					if (b == CH_CR)
						b = CH_LF;
				end
				default: b = octet_t'($urandom_range(8'h7E, 8'h21));
			endcase
			line_buf.push_back(b);
		end
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
	endfunction

	initial begin : stimulus
		int     counted;
		int     line_no;
		int     kind;
		int     idx;
		int     extra;
		octet_t b;

		counted = 0;
		line_no = 0;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.action = 1'b0;
		rx_if.data_byte = '0;
		tx_if.ready = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every field clamps (major, minor, status), empty reason,
		// a byte after acceptance, restart, then an error that must stick.
		line_buf.delete();
		put_text("HTTP/256.300 99999 ");
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
		line_buf.push_back(8'hFF);
		send_line_buf();
		send_beat(1'b1, 8'hA5);
		send_beat(1'b0, octet_t'("X"));
		send_beat(1'b0, 8'h00);

		// Random lines, each behind a restart. Mostly well-formed; the rest are
		// low status, a corrupted byte, CR without LF, cut-off lines and noise.
		while (counted < RANDOM_BEATS) begin
			line_no++;
			if (line_no % DRAIN_EVERY == 0)
				drain();
			kind = $urandom_range(19, 0);
			extra = 0;
			build_line(kind == 14);
			case (kind)
				15, 19: begin
					idx = $urandom_range(line_buf.size() - 1, 0);
					line_buf[idx] = octet_t'($urandom_range(255, 0));
				end
				16: begin
					do b = octet_t'($urandom_range(255, 0)); while (b == CH_LF);
					line_buf[$] = b;
				end
				17: begin
					repeat ($urandom_range(line_buf.size() - 1, 1))
						line_buf.delete(line_buf.size() - 1);
				end
				18: begin
					line_buf.delete();
					repeat ($urandom_range(20, 1))
						line_buf.push_back(octet_t'($urandom_range(255, 0)));
				end
				default: begin
					if ($urandom_range(3, 0) == 0)
						extra = $urandom_range(3, 1);  // trailing bytes, ignored after an accepted line
				end
			endcase
			counted += line_buf.size();
			repeat (extra)
				line_buf.push_back(octet_t'($urandom_range(255, 0)));
			send_beat(1'b1, octet_t'($urandom_range(255, 0)));
			send_line_buf();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.fail_count == 0 && board.pending.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
